### hdl/jtc_pkg.sv
// Shared types and constants for the joystick trim and calibration conditioner.
// Used by the channel interfaces, the scaler, the offset divider and the top level.
`timescale 1ns / 1ps

package jtc_pkg;

   // Number of samples averaged by one zero calibration.
   localparam int CAL_SAMPLES = 10;

   localparam int RAW_W      = 12;
   localparam int OUT_W      = 10;
   localparam int RAW_FULL   = 4095;
   localparam int OUT_MAX    = 1000;
   localparam int TRIM_W     = 11;
   localparam int TRIM_STEP  = 10;
   localparam int TRIM_LIMIT = 1000;
   localparam int OFS_W      = 13;
   localparam int DIFF_W     = RAW_W + 1;
   localparam int NUM_CH     = 4;
   localparam int CSR_IDX_W  = 2;

   // Calibration sum: magnitude bound is RAW_FULL * CAL_SAMPLES, plus a sign bit.
   localparam int SUM_W = $clog2(RAW_FULL * CAL_SAMPLES + 1) + 1;
   localparam int MAG_W = SUM_W - 1;
   localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

   // Exact reciprocal for dividing a MAG_W-bit magnitude by CAL_SAMPLES.
   localparam int DIV_SHIFT = MAG_W + $clog2(CAL_SAMPLES);
   localparam int MULT_W    = DIV_SHIFT + 1;
   localparam int DIV_MULT  = ((1 << DIV_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;

   // Channel order inside the per-channel arrays.
   localparam int CH_THROTTLE = 0;
   localparam int CH_YAW      = 1;
   localparam int CH_PITCH    = 2;
   localparam int CH_ROLL     = 3;

   typedef enum logic [2:0] {
      KEY_NONE        = 3'd0,
      KEY_UP          = 3'd1,
      KEY_DN          = 3'd2,
      KEY_LT          = 3'd3,
      KEY_RT          = 3'd4,
      KEY_TOP_LT      = 3'd5,
      KEY_TOP_RT      = 3'd6,
      KEY_TOP_LT_LONG = 3'd7
   } key_code_type;

   typedef enum logic {
      MODE_SAMPLE = 1'b0,
      MODE_KEY    = 1'b1
   } mode_type;

   // Reset values of the zero reference registers, in channel order.
   localparam logic [RAW_W-1:0] REF_RESET [NUM_CH] = '{12'd0, 12'd500, 12'd500, 12'd500};

   typedef struct packed {
      logic             mode;
      logic [RAW_W-1:0] throttle_raw;
      logic [RAW_W-1:0] yaw_raw;
      logic [RAW_W-1:0] pitch_raw;
      logic [RAW_W-1:0] roll_raw;
      logic [2:0]       key_code;
   } jtc_req_type;

   typedef struct packed {
      logic [OUT_W-1:0] throttle_out;
      logic [OUT_W-1:0] yaw_out;
      logic [OUT_W-1:0] pitch_out;
      logic [OUT_W-1:0] roll_out;
      logic             shutdown_flag;
      logic             altitude_hold_flag;
   } jtc_rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [RAW_W-1:0]     value;
   } jtc_csr_type;

endpackage

### hdl/jtc_req_if.sv
// Input channel: joystick samples and key events with a valid/ready handshake.
// Depends on jtc_pkg for the word layout.
`timescale 1ns / 1ps

interface jtc_req_if;
   import jtc_pkg::*;

   logic        valid;
   logic        ready;
   jtc_req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hdl/jtc_rsp_if.sv
// Result channel: conditioned stick values and flags with a valid/ready handshake.
// Depends on jtc_pkg for the word layout.
`timescale 1ns / 1ps

interface jtc_rsp_if;
   import jtc_pkg::*;

   logic        valid;
   logic        ready;
   jtc_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hdl/jtc_csr_if.sv
// Configuration write channel: register index and write data with valid/ready.
// Depends on jtc_pkg for the word layout.
`timescale 1ns / 1ps

interface jtc_csr_if;
   import jtc_pkg::*;

   logic        valid;
   logic        ready;
   jtc_csr_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hdl/joystick_trim_calibrate_conditioner.sv
// Joystick conditioner: scaling, zero offset, key trim and zero calibration.
// A sample word passes the input stage, then the result stage. One word per cycle
// while results are taken; the input stage holds after the last calibration sample
// while the new offsets are divided out. Key words produce no result. Synchronous
// reset clears trims, offsets, calibration and flags and loads reference defaults.
`timescale 1ns / 1ps

module joystick_trim_calibrate_conditioner (
   input logic    clock,
   input logic    reset,
   jtc_req_if.sink   req_if,
   jtc_rsp_if.source rsp_if,
   jtc_csr_if.sink   csr_if
);
   import jtc_pkg::*;

   localparam int V_W = 15;
   localparam logic signed [V_W-1:0]    V_MAX   = V_W'(OUT_MAX);
   localparam logic signed [TRIM_W:0]   TRIM_HI = (TRIM_W + 1)'(TRIM_LIMIT);
   localparam logic signed [TRIM_W:0]   TRIM_LO = -TRIM_HI;
   localparam logic signed [TRIM_W:0]   STEP_V  = (TRIM_W + 1)'(TRIM_STEP);

   function automatic logic signed [TRIM_W-1:0] trim_add(
      input logic signed [TRIM_W-1:0] t,
      input logic                     up
   );
      logic signed [TRIM_W:0] v;
      begin
         v = up ? ($signed({t[TRIM_W-1], t}) + STEP_V) : ($signed({t[TRIM_W-1], t}) - STEP_V);
         if (v > TRIM_HI) begin
            v = TRIM_HI;
         end else if (v < TRIM_LO) begin
            v = TRIM_LO;
         end
         return v[TRIM_W-1:0];
      end
   endfunction

   function automatic logic [OUT_W-1:0] clamp_out(input logic signed [V_W-1:0] v);
      begin
         if (v < 0) begin
            return '0;
         end else if (v > V_MAX) begin
            return OUT_W'(OUT_MAX);
         end
         return v[OUT_W-1:0];
      end
   endfunction

   // Input stage
   logic              a_valid_ff, a_valid_in;
   jtc_req_type       a_req_ff;
   logic [OUT_W-1:0]  a_scaled_ff [NUM_CH];
   logic [OUT_W-1:0]  req_scaled [NUM_CH];
   logic [RAW_W-1:0]  req_raw [NUM_CH];
   logic [RAW_W-1:0]  a_raw [NUM_CH];

   // Result stage
   logic              rsp_valid_ff, rsp_valid_in;
   jtc_rsp_type       rsp_data_ff, rsp_data_in;

   // Block state
   logic [RAW_W-1:0]          ref_ff [NUM_CH];
   logic [RAW_W-1:0]          ref_in [NUM_CH];
   logic signed [OFS_W-1:0]   ofs_ff [NUM_CH];
   logic signed [OFS_W-1:0]   ofs_in [NUM_CH];
   logic signed [SUM_W-1:0]   sum_ff [NUM_CH];
   logic signed [SUM_W-1:0]   sum_in [NUM_CH];
   logic signed [OFS_W-1:0]   div_quot [NUM_CH];
   logic signed [TRIM_W-1:0]  pitch_trim_ff, pitch_trim_in;
   logic signed [TRIM_W-1:0]  roll_trim_ff, roll_trim_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      calib_ff, calib_in;
   logic                      div_pending_ff, div_pending_in;
   logic                      shutdown_ff, shutdown_in;
   logic                      altitude_ff, altitude_in;

   logic                      out_free;
   logic                      a_is_key;
   logic                      a_fire;
   logic                      req_fire;
   logic                      csr_fire;
   logic signed [V_W-1:0]     chan_v [NUM_CH];
   logic [OUT_W-1:0]          chan_out [NUM_CH];
   logic signed [SUM_W-1:0]   diff_ext [NUM_CH];
   logic signed [DIFF_W-1:0]  diff [NUM_CH];

   assign req_raw[CH_THROTTLE] = req_if.data.throttle_raw;
   assign req_raw[CH_YAW]      = req_if.data.yaw_raw;
   assign req_raw[CH_PITCH]    = req_if.data.pitch_raw;
   assign req_raw[CH_ROLL]     = req_if.data.roll_raw;

   assign a_raw[CH_THROTTLE] = a_req_ff.throttle_raw;
   assign a_raw[CH_YAW]      = a_req_ff.yaw_raw;
   assign a_raw[CH_PITCH]    = a_req_ff.pitch_raw;
   assign a_raw[CH_ROLL]     = a_req_ff.roll_raw;

   for (genvar g = 0; g < NUM_CH; g++) begin : g_chan
      jtc_scale u_scale (
         .raw    (req_raw[g]),
         .scaled (req_scaled[g])
      );

      jtc_div u_div (
         .sum  (sum_ff[g]),
         .quot (div_quot[g])
      );
   end

   // A key word never needs the result register; a sample waits for it. While the
   // new offsets are being divided out, the word in the input stage holds.
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign a_is_key = (a_req_ff.mode == MODE_KEY);
   assign a_fire   = a_valid_ff && !div_pending_ff && (a_is_key || out_free);
   assign req_fire = req_if.valid && req_if.ready;
   assign csr_fire = csr_if.valid && csr_if.ready;

   assign req_if.ready = !a_valid_ff || a_fire;
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   // Conditioning of the word in the input stage.
   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         chan_v[i] = $signed({{(V_W - OUT_W){1'b0}}, a_scaled_ff[i]})
                   - $signed({{(V_W - OFS_W){ofs_ff[i][OFS_W-1]}}, ofs_ff[i]});
         if (i == CH_PITCH) begin
            chan_v[i] = chan_v[i]
                      + $signed({{(V_W - TRIM_W){pitch_trim_ff[TRIM_W-1]}}, pitch_trim_ff});
         end else if (i == CH_ROLL) begin
            chan_v[i] = chan_v[i]
                      + $signed({{(V_W - TRIM_W){roll_trim_ff[TRIM_W-1]}}, roll_trim_ff});
         end
         chan_out[i] = clamp_out(chan_v[i]);
         diff[i]     = $signed({1'b0, a_raw[i]}) - $signed({1'b0, ref_ff[i]});
         diff_ext[i] = $signed({{(SUM_W - DIFF_W){diff[i][DIFF_W-1]}}, diff[i]});
      end

      rsp_data_in.throttle_out       = chan_out[CH_THROTTLE];
      rsp_data_in.yaw_out            = chan_out[CH_YAW];
      rsp_data_in.pitch_out          = chan_out[CH_PITCH];
      rsp_data_in.roll_out           = chan_out[CH_ROLL];
      rsp_data_in.shutdown_flag      = shutdown_ff;
      rsp_data_in.altitude_hold_flag = altitude_ff;
   end

   // Next state of the handshake stages and of the block state.
   always_comb begin
      a_valid_in     = a_valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      ref_in         = ref_ff;
      ofs_in         = ofs_ff;
      sum_in         = sum_ff;
      pitch_trim_in  = pitch_trim_ff;
      roll_trim_in   = roll_trim_ff;
      count_in       = count_ff;
      calib_in       = calib_ff;
      div_pending_in = div_pending_ff;
      shutdown_in    = shutdown_ff;
      altitude_in    = altitude_ff;

      if (req_fire) begin
         a_valid_in = 1'b1;
      end else if (a_fire) begin
         a_valid_in = 1'b0;
      end

      if (a_fire && !a_is_key) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_fire) begin
         ref_in[csr_if.data.index] = csr_if.data.value;
      end

      // The final sums were stored last cycle; turn them into offsets.
      if (div_pending_ff) begin
         for (int i = 0; i < NUM_CH; i++) begin
            ofs_in[i] = div_quot[i];
            sum_in[i] = '0;
         end
         div_pending_in = 1'b0;
      end

      if (a_fire) begin
         if (a_is_key) begin
            unique case (a_req_ff.key_code)
               KEY_UP:     pitch_trim_in = trim_add(pitch_trim_ff, 1'b1);
               KEY_DN:     pitch_trim_in = trim_add(pitch_trim_ff, 1'b0);
               KEY_LT:     roll_trim_in  = trim_add(roll_trim_ff, 1'b0);
               KEY_RT:     roll_trim_in  = trim_add(roll_trim_ff, 1'b1);
               KEY_TOP_LT: shutdown_in   = 1'b1;
               KEY_TOP_RT: altitude_in   = 1'b1;
               KEY_TOP_LT_LONG: begin
                  pitch_trim_in = '0;
                  roll_trim_in  = '0;
                  for (int i = 0; i < NUM_CH; i++) begin
                     sum_in[i] = '0;
                  end
                  count_in = '0;
                  calib_in = 1'b1;
               end
               default: ;
            endcase
         end else if (calib_ff) begin
            for (int i = 0; i < NUM_CH; i++) begin
               sum_in[i] = sum_ff[i] + diff_ext[i];
            end
            if (count_ff == CNT_W'(CAL_SAMPLES - 1)) begin
               count_in       = '0;
               calib_in       = 1'b0;
               div_pending_in = 1'b1;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         ref_ff         <= REF_RESET;
         pitch_trim_ff  <= '0;
         roll_trim_ff   <= '0;
         count_ff       <= '0;
         calib_ff       <= 1'b0;
         div_pending_ff <= 1'b0;
         shutdown_ff    <= 1'b0;
         altitude_ff    <= 1'b0;
         for (int i = 0; i < NUM_CH; i++) begin
            ofs_ff[i] <= '0;
            sum_ff[i] <= '0;
         end
      end else begin
         a_valid_ff     <= a_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         ref_ff         <= ref_in;
         ofs_ff         <= ofs_in;
         sum_ff         <= sum_in;
         pitch_trim_ff  <= pitch_trim_in;
         roll_trim_ff   <= roll_trim_in;
         count_ff       <= count_in;
         calib_ff       <= calib_in;
         div_pending_ff <= div_pending_in;
         shutdown_ff    <= shutdown_in;
         altitude_ff    <= altitude_in;
      end
   end

   // Payload registers load on their stage's handshake and need no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_req_ff    <= req_if.data;
         a_scaled_ff <= req_scaled;
      end
      if (a_fire && !a_is_key) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

### hdl/jtc_scale.sv
// Scales and inverts one raw converter sample to 1000 - raw*1000/4095, truncating.
// Depends on jtc_pkg for widths and constants.
`timescale 1ns / 1ps

module jtc_scale (
   input  logic [jtc_pkg::RAW_W-1:0] raw,
   output logic [jtc_pkg::OUT_W-1:0] scaled
);
   import jtc_pkg::*;

   localparam int PROD_W = RAW_W + OUT_W;

   logic [PROD_W-1:0] prod;
   logic [OUT_W-1:0]  quot_lo;
   logic [RAW_W:0]    rem;
   logic [OUT_W-1:0]  quot;

   // n/4095 is n/4096 or one more: the remainder against 4095 is
   // (n mod 4096) + floor(n/4096), which stays below twice 4095.
   always_comb begin
      prod    = PROD_W'(raw) * PROD_W'(OUT_MAX);
      quot_lo = prod[PROD_W-1 -: OUT_W];
      rem     = {1'b0, prod[RAW_W-1:0]} + (RAW_W + 1)'(quot_lo);
      quot    = (rem >= (RAW_W + 1)'(RAW_FULL)) ? quot_lo + OUT_W'(1) : quot_lo;
      scaled  = OUT_W'(OUT_MAX) - quot;
   end

endmodule

### hdl/jtc_div.sv
// Divides a signed calibration sum by CAL_SAMPLES, truncating toward zero.
// Uses an exact reciprocal multiply on the magnitude; depends on jtc_pkg.
`timescale 1ns / 1ps

module jtc_div (
   input  logic signed [jtc_pkg::SUM_W-1:0] sum,
   output logic signed [jtc_pkg::OFS_W-1:0] quot
);
   import jtc_pkg::*;

   localparam int               PROD_W     = MAG_W + MULT_W;
   localparam logic [MULT_W-1:0] DIV_MULT_V = MULT_W'(DIV_MULT);

   logic              neg;
   logic [SUM_W-1:0]  mag_full;
   logic [MAG_W-1:0]  mag;
   logic [PROD_W-1:0] prod;
   logic [OFS_W-2:0]  quot_mag;

   always_comb begin
      neg      = sum[SUM_W-1];
      mag_full = neg ? (-sum) : sum;
      mag      = mag_full[MAG_W-1:0];
      prod     = {{MULT_W{1'b0}}, mag} * {{MAG_W{1'b0}}, DIV_MULT_V};
      quot_mag = prod[DIV_SHIFT +: (OFS_W - 1)];
      quot     = neg ? -$signed({1'b0, quot_mag}) : $signed({1'b0, quot_mag});
   end

endmodule
